>>> hdl/fjt_pkg.sv
// shared types, constants and helpers of the flat json pair tokenizer
`default_nettype none

package fjt_pkg;

    localparam int MAX_PAIRS_DEF  = 16;
    localparam int HELD_DEPTH_DEF = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] KIND_KEY_CHAR = 3'd0;
    localparam logic [2:0] KIND_VAL_CHAR = 3'd1;
    localparam logic [2:0] KIND_KEY_END  = 3'd2;
    localparam logic [2:0] KIND_VAL_END  = 3'd3;
    localparam logic [2:0] KIND_EOM      = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_KEY,
        MODE_VSKIP,
        MODE_VAL
    } mode_t;

    typedef enum logic [2:0] {
        OP_WS,
        OP_WS_OVF,
        OP_CHAR,
        OP_MARK,
        OP_EOM
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_HELD,
        ST_CHAR,
        ST_MARK,
        ST_EOM
    } bstate_t;

    typedef struct packed {
        op_t        op;
        logic       is_val;
        logic       close;
        logic [7:0] ch;
        logic [3:0] idx;
        logic       ovf;
        logic [4:0] cnt;
    } cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

>>> hdl/flat_json_pair_tokenizer.sv
// top level: one text byte per input item, one key or value character, token end or
//   message end per result item; an accepted byte goes through the command queue and then
//   the result register, and held spaces go out first, each read from the held buffer ram
// throughput: one byte per cycle while the queue has room; a byte releasing held spaces,
//   an early release or a message end holds the back end; the queue stalls the input
// reset: rst_n asynchronous active low clears token state, queue and result valid flag
`default_nettype none

module flat_json_pair_tokenizer
    import fjt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      char_out,
    output logic [3:0]      pair_index,
    output logic [4:0]      pair_count,
    output logic            pair_overflow,
    output logic            space_overflow,
    output logic            last
);

    logic push;
    cmd_t push_data;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_data;

    fjt_front #(
        .MAX_PAIRS  (MAX_PAIRS),
        .HELD_DEPTH (HELD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .push      (push),
        .push_data (push_data),
        .full      (q_full)
    );

    fjt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    fjt_back #(
        .HELD_DEPTH (HELD_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .char_out       (char_out),
        .pair_index     (pair_index),
        .pair_count     (pair_count),
        .pair_overflow  (pair_overflow),
        .space_overflow (space_overflow),
        .last           (last)
    );

endmodule

`default_nettype wire

>>> hdl/fjt_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fjt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/fjt_front.sv
// front part: takes input items, tracks token state and issues commands
`default_nettype none

module fjt_front
    import fjt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    output logic            push,
    output cmd_t            push_data,
    input  wire logic       full
);

    localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CW = $clog2(HELD_DEPTH + 1);

    mode_t           mode_reg, mode_next;
    logic            started_reg, started_next;
    logic [CW-1:0]   held_reg, held_next;
    logic [PW-1:0]   pair_reg, pair_next;
    logic            exceeded_reg, exceeded_next;

    logic            accept;
    logic [PW+4:0]   pair_wide;
    logic [PW+4:0]   count_wide;
    logic [3:0]      idx_clamped;
    logic [4:0]      cnt_clamped;
    logic            tok;
    logic            tok_val;
    logic            do_next;

    assign in_ready    = !full;
    assign accept      = in_valid && !full;
    assign pair_wide   = (PW + 5)'(pair_reg);
    assign count_wide  = pair_wide + 1'b1;
    assign idx_clamped = (pair_wide > (PW + 5)'(15)) ? 4'hF : pair_wide[3:0];
    assign cnt_clamped = (count_wide > (PW + 5)'(31)) ? 5'd31 : count_wide[4:0];

    always_comb
    begin
        mode_next        = mode_reg;
        started_next     = started_reg;
        held_next        = held_reg;
        pair_next        = pair_reg;
        exceeded_next    = exceeded_reg;
        push             = 1'b0;
        push_data.op     = OP_CHAR;
        push_data.is_val = 1'b0;
        push_data.close  = 1'b0;
        push_data.ch     = char_in;
        push_data.idx    = idx_clamped;
        push_data.ovf    = exceeded_reg;
        push_data.cnt    = 5'd0;
        tok              = 1'b0;
        tok_val          = 1'b0;
        do_next          = 1'b0;

        if (accept)
        begin
            if (char_in == CH_NUL)
            begin
                push             = 1'b1;
                push_data.op     = OP_EOM;
                push_data.close  = (mode_reg != MODE_IDLE);
                push_data.is_val = (mode_reg == MODE_VSKIP) || (mode_reg == MODE_VAL);
                push_data.cnt    = cnt_clamped;
                mode_next        = MODE_IDLE;
                started_next     = 1'b0;
                held_next        = '0;
                pair_next        = '0;
                exceeded_next    = 1'b0;
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        if (char_in == CH_QUOTE)
                        begin
                            mode_next    = MODE_KEY;
                            started_next = 1'b0;
                            held_next    = '0;
                        end
                        else if (char_in == CH_COLON)
                        begin
                            mode_next    = MODE_VSKIP;
                            started_next = 1'b0;
                            held_next    = '0;
                        end
                        else if (char_in == CH_COMMA)
                        begin
                            do_next = 1'b1;
                        end
                    end
                    MODE_KEY:
                    begin
                        if (char_in == CH_QUOTE)
                        begin
                            push             = 1'b1;
                            push_data.op     = OP_MARK;
                            push_data.is_val = 1'b0;
                            mode_next        = MODE_IDLE;
                            started_next     = 1'b0;
                            held_next        = '0;
                        end
                        else
                        begin
                            tok = 1'b1;
                        end
                    end
                    default:
                    begin
                        if ((mode_reg == MODE_VSKIP) &&
                            ((char_in == CH_SPACE) || (char_in == CH_QUOTE)))
                        begin
                            mode_next = mode_reg;
                        end
                        else if ((char_in == CH_QUOTE) || (char_in == CH_COMMA) ||
                                 (char_in == CH_RBRACE))
                        begin
                            push             = 1'b1;
                            push_data.op     = OP_MARK;
                            push_data.is_val = 1'b1;
                            mode_next        = MODE_IDLE;
                            started_next     = 1'b0;
                            held_next        = '0;
                            do_next          = (char_in == CH_COMMA);
                        end
                        else
                        begin
                            mode_next = MODE_VAL;
                            tok       = 1'b1;
                            tok_val   = 1'b1;
                        end
                    end
                endcase

                if (tok)
                begin
                    push_data.is_val = tok_val;
                    if (is_ws(char_in))
                    begin
                        if (started_reg)
                        begin
                            push = 1'b1;
                            if (held_reg == CW'(HELD_DEPTH))
                            begin
                                push_data.op = OP_WS_OVF;
                            end
                            else
                            begin
                                push_data.op = OP_WS;
                                held_next    = held_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        push         = 1'b1;
                        push_data.op = OP_CHAR;
                        held_next    = '0;
                        started_next = 1'b1;
                    end
                end

                if (do_next)
                begin
                    if (pair_reg == PW'(MAX_PAIRS - 1))
                    begin
                        exceeded_next = 1'b1;
                    end
                    else
                    begin
                        pair_next = pair_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            started_reg  <= 1'b0;
            held_reg     <= '0;
            pair_reg     <= '0;
            exceeded_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            started_reg  <= started_next;
            held_reg     <= held_next;
            pair_reg     <= pair_next;
            exceeded_reg <= exceeded_next;
        end
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(HELD_DEPTH))
        else $error("held whitespace count beyond buffer depth");

    a_exceeded_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        exceeded_reg |-> (pair_reg == PW'(MAX_PAIRS - 1)))
        else $error("pair overflow without saturated pair index");

    a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (char_in == CH_NUL)) |=>
            ((mode_reg == MODE_IDLE) && (pair_reg == '0) && !exceeded_reg))
        else $error("end of message did not clear token state");

endmodule

`default_nettype wire

>>> hdl/fjt_queue.sv
// two entry command queue between front and back
`default_nettype none

module fjt_queue
    import fjt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output cmd_t      pop_data
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fjt_back.sv
// back part: runs commands, holds trailing whitespace and drives the result register
`default_nettype none

module fjt_back
    import fjt_pkg::*;
#(
    parameter int HELD_DEPTH = HELD_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  cmd_t            q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      kind,
    output logic [7:0]      char_out,
    output logic [3:0]      pair_index,
    output logic [4:0]      pair_count,
    output logic            pair_overflow,
    output logic            space_overflow,
    output logic            last
);

    localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CW = $clog2(HELD_DEPTH + 1);

    bstate_t       state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic          out_valid_reg;
    logic [2:0]    kind_reg;
    logic [7:0]    char_out_reg;
    logic [3:0]    pair_index_reg;
    logic [4:0]    pair_count_reg;
    logic          pair_overflow_reg;
    logic          space_overflow_reg;
    logic          last_reg;

    logic          slot_free;
    logic          emit;
    logic [2:0]    e_kind;
    logic [7:0]    e_ch;
    logic [3:0]    e_idx;
    logic [4:0]    e_cnt;
    logic          e_ovf;
    logic          e_sov;
    logic          e_last;

    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(HELD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    fjt_ram #(
        .WIDTH (8),
        .DEPTH (HELD_DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = cmd_reg.ch;
        emit        = 1'b0;
        e_kind      = KIND_KEY_CHAR;
        e_ch        = 8'd0;
        e_idx       = cmd_reg.idx;
        e_cnt       = 5'd0;
        e_ovf       = cmd_reg.ovf;
        e_sov       = 1'b0;
        e_last      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    e_idx    = q_data.idx;
                    e_ovf    = q_data.ovf;
                    case (q_data.op)
                        OP_WS:
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = q_data.ch;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            cnt_next    = cnt_reg + 1'b1;
                        end
                        OP_WS_OVF:
                        begin
                            state_next = ST_FETCH;
                        end
                        OP_CHAR:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_FETCH;
                            end
                            else if (slot_free)
                            begin
                                emit   = 1'b1;
                                e_kind = q_data.is_val ? KIND_VAL_CHAR : KIND_KEY_CHAR;
                                e_ch   = q_data.ch;
                                e_last = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_CHAR;
                            end
                        end
                        OP_MARK:
                        begin
                            if (slot_free)
                            begin
                                emit        = 1'b1;
                                e_kind      = q_data.is_val ? KIND_VAL_END : KIND_KEY_END;
                                e_last      = 1'b1;
                                wr_ptr_next = '0;
                                rd_ptr_next = '0;
                                cnt_next    = '0;
                            end
                            else
                            begin
                                state_next = ST_MARK;
                            end
                        end
                        OP_EOM:
                        begin
                            state_next = q_data.close ? ST_MARK : ST_EOM;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                ram_re     = 1'b1;
                state_next = ST_HELD;
            end
            ST_HELD:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    e_kind      = cmd_reg.is_val ? KIND_VAL_CHAR : KIND_KEY_CHAR;
                    e_ch        = ram_rdata;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    if (cmd_reg.op == OP_WS_OVF)
                    begin
                        e_sov       = 1'b1;
                        e_last      = 1'b1;
                        ram_we      = 1'b1;
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = (cnt_reg == CW'(1)) ? ST_CHAR : ST_FETCH;
                    end
                end
            end
            ST_CHAR:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_kind     = cmd_reg.is_val ? KIND_VAL_CHAR : KIND_KEY_CHAR;
                    e_ch       = cmd_reg.ch;
                    e_last     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    e_kind      = cmd_reg.is_val ? KIND_VAL_END : KIND_KEY_END;
                    e_last      = (cmd_reg.op != OP_EOM);
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    cnt_next    = '0;
                    state_next  = (cmd_reg.op == OP_EOM) ? ST_EOM : ST_IDLE;
                end
            end
            ST_EOM:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    e_kind      = KIND_EOM;
                    e_cnt       = cmd_reg.cnt;
                    e_last      = 1'b1;
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            kind_reg           <= e_kind;
            char_out_reg       <= e_ch;
            pair_index_reg     <= e_idx;
            pair_count_reg     <= e_cnt;
            pair_overflow_reg  <= e_ovf;
            space_overflow_reg <= e_sov;
            last_reg           <= e_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign char_out       = char_out_reg;
    assign pair_index     = pair_index_reg;
    assign pair_count     = pair_count_reg;
    assign pair_overflow  = pair_overflow_reg;
    assign space_overflow = space_overflow_reg;
    assign last           = last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(HELD_DEPTH))
        else $error("held buffer count beyond depth");

    a_held_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HELD) |->
            (($past(state_reg) == ST_FETCH) || ($past(state_reg) == ST_HELD)))
        else $error("held read data used without a fetch");

    a_eom_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_EOM)) |->
            (last_reg && (pair_count_reg != 5'd0)))
        else $error("end of message without last or pair count");

endmodule

`default_nettype wire

>>> test/tb.sv
// testbench of the flat json pair tokenizer: directed and random text with a scoreboard
`default_nettype none

module tb
    import fjt_pkg::*;
;

    localparam int ITEM_TARGET = 260;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX = 10;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic [3:0] idx;
        logic [4:0] cnt;
        logic       povf;
        logic       sovf;
        logic       last;
    } token_result_t;

    class token_scoreboard;
        mode_t         tok_mode;
        bit            started;
        logic [7:0]    held[$];
        int unsigned   pair_no;
        bit            exceeded;
        token_result_t step_q[$];
        token_result_t pending_q[$];
        int unsigned   errors;
        int unsigned   items_used;
        int unsigned   checked;
        int unsigned   eom_seen;
        int unsigned   spill_seen;
        int unsigned   pair_ovf_seen;

        function new();
            clear_state();
            errors = 0;
            items_used = 0;
            checked = 0;
            eom_seen = 0;
            spill_seen = 0;
            pair_ovf_seen = 0;
        endfunction

        function void clear_state();
            tok_mode = MODE_IDLE;
            started = 1'b0;
            held.delete();
            pair_no = 0;
            exceeded = 1'b0;
        endfunction

        function bit blank_char(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void push_result(logic [2:0] k, logic [7:0] c, int unsigned cnt, bit sov);
            token_result_t r;
            r.kind = k;
            r.ch   = c;
            r.idx  = (pair_no > 15) ? 4'd15 : 4'(pair_no);
            r.cnt  = (cnt > 31) ? 5'd31 : 5'(cnt);
            r.povf = exceeded;
            r.sovf = sov;
            r.last = 1'b0;
            step_q.push_back(r);
        endfunction

        function void advance_pair();
            if (pair_no + 1 >= MAX_PAIRS_DEF)
                exceeded = 1'b1;
            else
                pair_no++;
        endfunction

        function void close_token();
            tok_mode = MODE_IDLE;
            started = 1'b0;
            held.delete();
        endfunction

        function void token_byte(logic [7:0] c, logic [2:0] k);
            if (blank_char(c))
            begin
                if (!started)
                    return;
                // buffer full: oldest held blank goes out early
                if (held.size() >= HELD_DEPTH_DEF)
                begin
                    push_result(k, held.pop_front(), 0, 1'b1);
                    spill_seen++;
                end
                held.push_back(c);
                return;
            end
            foreach (held[i])
                push_result(k, held[i], 0, 1'b0);
            held.delete();
            started = 1'b1;
            push_result(k, c, 0, 1'b0);
        endfunction

        // predicts the results of one accepted item, returns 0 if the item is ignored
        function bit note_byte(logic [7:0] c);
            bit effective;
            effective = 1'b1;
            step_q.delete();
            if (c == CH_NUL)
            begin
                if (tok_mode == MODE_KEY)
                    push_result(KIND_KEY_END, 8'h00, 0, 1'b0);
                else if (tok_mode == MODE_VSKIP || tok_mode == MODE_VAL)
                    push_result(KIND_VAL_END, 8'h00, 0, 1'b0);
                push_result(KIND_EOM, 8'h00, pair_no + 1, 1'b0);
                if (exceeded)
                    pair_ovf_seen++;
                eom_seen++;
                clear_state();
            end
            else if (tok_mode == MODE_IDLE)
            begin
                if (c == CH_QUOTE)
                begin
                    tok_mode = MODE_KEY;
                    started = 1'b0;
                    held.delete();
                end
                else if (c == CH_COLON)
                begin
                    tok_mode = MODE_VSKIP;
                    started = 1'b0;
                    held.delete();
                end
                else if (c == CH_COMMA)
                    advance_pair();
                else
                    effective = 1'b0;
            end
            else if (tok_mode == MODE_KEY)
            begin
                if (c == CH_QUOTE)
                begin
                    push_result(KIND_KEY_END, 8'h00, 0, 1'b0);
                    close_token();
                end
                else
                    token_byte(c, KIND_KEY_CHAR);
            end
            else
            begin
                if (tok_mode == MODE_VSKIP && (c == CH_SPACE || c == CH_QUOTE))
                    effective = 1'b0;
                else if (c == CH_QUOTE || c == CH_COMMA || c == CH_RBRACE)
                begin
                    push_result(KIND_VAL_END, 8'h00, 0, 1'b0);
                    close_token();
                    if (c == CH_COMMA)
                        advance_pair();
                end
                else
                begin
                    tok_mode = MODE_VAL;
                    token_byte(c, KIND_VAL_CHAR);
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                pending_q.push_back(step_q[i]);
            if (effective)
                items_used++;
            return effective;
        endfunction

        function void check_result(token_result_t got);
            token_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("tb: unexpected result kind %0d char %h idx %0d count %0d",
                             got.kind, got.ch, got.idx, got.cnt);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"tb: mismatch (exp/got) kind %0d/%0d char %h/%h idx %0d/%0d ",
                              "count %0d/%0d povf %0b/%0b sovf %0b/%0b last %0b/%0b"},
                             want.kind, got.kind, want.ch, got.ch, want.idx, got.idx,
                             want.cnt, got.cnt, want.povf, got.povf, want.sovf, got.sovf,
                             want.last, got.last);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_in = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [3:0] pair_index;
    logic [4:0] pair_count;
    logic       pair_overflow;
    logic       space_overflow;
    logic       last;

    token_scoreboard sb = new();
    logic [7:0]      text_q[$];
    int              gap_pct = 0;
    int              stall_pct = 0;
    int unsigned     byte_count = 0;
    int unsigned     cycle_count = 0;

    flat_json_pair_tokenizer u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .char_out       (char_out),
        .pair_index     (pair_index),
        .pair_count     (pair_count),
        .pair_overflow  (pair_overflow),
        .space_overflow (space_overflow),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_len(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    // result side: random stalls, check on every handshake
    initial
    begin
        int            stall_left;
        token_result_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{kind, char_out, pair_index, pair_count, pair_overflow,
                        space_overflow, last};
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (rst_n && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = pick_len(100) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= rst_n;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = pick_len(gap_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        do
            @(posedge clk);
        while (!in_ready);
        void'(sb.note_byte(c));
        byte_count++;
    endtask

    function automatic logic [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : 8'(CH_TAB + pick);
    endfunction

    function automatic logic [7:0] rand_key_byte();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(8'h2C, 8'h7A));
        while (c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] rand_value_byte();
        logic [7:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                            : 8'($urandom_range(8'h2C, 8'h7A));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_RBRACE);
        return c;
    endfunction

    task automatic add_blanks(input int n);
        repeat (n) text_q.push_back(rand_blank());
    endtask

    task automatic add_token(input bit is_value, input int max_len, input bit long_run);
        int len;
        len = $urandom_range(0, max_len);
        if ($urandom_range(0, 3) == 0)
            add_blanks($urandom_range(1, 2));
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 7) == 0)
                add_blanks(($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                                       : $urandom_range(1, 3));
            text_q.push_back(is_value ? rand_value_byte() : rand_key_byte());
        end
        // overfill the blank buffer between two characters
        if (long_run)
        begin
            text_q.push_back("q");
            add_blanks(18);
            text_q.push_back("r");
        end
        if ($urandom_range(0, 3) == 0)
            add_blanks($urandom_range(1, 2));
    endtask

    task automatic build_message(input int msg_no);
        int pairs;
        int max_len;
        int cut;
        bit big;
        bit quoted;
        text_q.delete();
        big = (msg_no == 1);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(1, 255)));
        pairs = big ? $urandom_range(15, 19) : $urandom_range(1, 4);
        max_len = big ? 1 : 5;
        if ($urandom_range(0, 1))
            text_q.push_back(CH_LBRACE);
        for (int p = 0; p < pairs; p++)
        begin
            text_q.push_back(CH_QUOTE);
            add_token(1'b0, max_len, msg_no == 0 && p == 0);
            text_q.push_back(CH_QUOTE);
            if ($urandom_range(0, 2) == 0)
                text_q.push_back(CH_SPACE);
            text_q.push_back(CH_COLON);
            if ($urandom_range(0, 1))
                text_q.push_back(CH_SPACE);
            quoted = 1'($urandom_range(0, 1));
            if (quoted)
                text_q.push_back(CH_QUOTE);
            add_token(1'b1, max_len, 1'b0);
            if (quoted)
                text_q.push_back(CH_QUOTE);
            if (p < pairs - 1)
                text_q.push_back(CH_COMMA);
        end
        if ($urandom_range(0, 1))
            text_q.push_back(CH_RBRACE);
        // truncated message
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(0, text_q.size() - 1);
            while (text_q.size() > cut)
                void'(text_q.pop_back());
        end
        text_q.push_back(CH_NUL);
    endtask

    initial
    begin
        int msg_no;
        msg_no = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 30;
        stall_pct = 30;
        text_q = '{CH_NUL, 8'h01,
                   CH_QUOTE, CH_QUOTE,
                   CH_COLON, CH_TAB, "v", CH_SPACE, 8'hFF, CH_RBRACE,
                   CH_COMMA,
                   CH_QUOTE, CH_COMMA, CH_SPACE, CH_QUOTE,
                   CH_COLON, CH_SPACE, CH_QUOTE, "7", CH_COMMA,
                   CH_QUOTE, "k", CH_CR, CH_NUL};
        foreach (text_q[i])
            send_byte(text_q[i]);

        while (byte_count < ITEM_TARGET)
        begin
            build_message(msg_no);
            gap_pct = pick_pct();
            stall_pct = pick_pct();
            foreach (text_q[i])
                send_byte(text_q[i]);
            msg_no++;
        end
        in_valid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d text bytes (%0d not ignored), %0d random messages, %0d results checked",
                 byte_count, sb.items_used, msg_no, sb.checked);
        $display("tb: %0d message ends, %0d of them past the pair limit, %0d early blank releases",
                 sb.eom_seen, sb.pair_ovf_seen, sb.spill_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb: success");
        else
        begin
            $display("tb: %0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
